// File: hdl/mmr_pkg.sv
// ----------------------------------------------------------------------------
// mmr_pkg
// Shared widths, state types and the status struct of the modular multiplier.
// ----------------------------------------------------------------------------
package mmr_pkg;

   localparam int WORD_W    = 64;
   localparam int NUM_WORDS = 3;
   localparam int OP_W      = WORD_W * NUM_WORDS;
   localparam int PROD_W    = 2 * OP_W;
   localparam int STEP_W    = 9;
   localparam int IDX_W     = 2;
   localparam int MCNT_W    = $clog2(OP_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_RED,
      ST_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_NORM,
      RD_SUB
   } red_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } red_status_type;

endpackage

// File: hdl/mmr_reduce.sv
// ----------------------------------------------------------------------------
// mmr_reduce
// Restoring shift-and-subtract reduction of a double-width product.
// ----------------------------------------------------------------------------
module mmr_reduce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mmr_pkg::PROD_W-1:0]  product,
   input  logic [mmr_pkg::OP_W-1:0]    modulus,
   output logic [mmr_pkg::OP_W-1:0]    remainder,
   output mmr_pkg::red_status_type     status
);
   import mmr_pkg::*;

   red_state_type       state_ff, state_in;
   logic [PROD_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]   sm_ff, sm_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic [PROD_W:0]     diff;

   localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

   assign diff = {1'b0, rem_ff} - {1'b0, sm_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RD_IDLE: if (start) state_in = RD_NORM;
         RD_NORM: if (sm_ff[PROD_W-1]) state_in = RD_SUB;
         RD_SUB:  if (steps_ff == STEP_ONE) state_in = RD_IDLE;
         default: state_in = RD_IDLE;
      endcase
   end

   always_comb begin
      status.busy = (state_ff != RD_IDLE);
      status.done = (state_ff == RD_SUB) && (steps_ff == STEP_ONE);
   end

   always_comb begin
      rem_in   = rem_ff;
      sm_in    = sm_ff;
      steps_in = steps_ff;
      if (start && state_ff == RD_IDLE) begin
         rem_in   = product;
         sm_in    = {{OP_W{1'b0}}, modulus};
         steps_in = STEP_ONE;
      end else if (state_ff == RD_NORM) begin
         if (!sm_ff[PROD_W-1]) begin
            sm_in    = {sm_ff[PROD_W-2:0], 1'b0};
            steps_in = steps_ff + STEP_ONE;
         end
      end else if (state_ff == RD_SUB) begin
         // A borrow out of the top means the shifted modulus is larger.
         if (!diff[PROD_W]) rem_in = diff[PROD_W-1:0];
         sm_in    = {1'b0, sm_ff[PROD_W-1:1]};
         steps_in = steps_ff - STEP_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RD_IDLE;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         steps_ff <= steps_in;
      end
      rem_ff <= rem_in;
      sm_ff  <= sm_in;
   end

   assign remainder = rem_ff[OP_W-1:0];

endmodule

// File: hdl/modular_multiply_restoring.sv
// ----------------------------------------------------------------------------
// modular_multiply_restoring
// Computes (a * b) mod m for 192-bit operands given as three 64-bit words.
// ----------------------------------------------------------------------------
// Usage: write the modulus words through the csr_ channel (index 0 low,
// 1 mid, 2 high) while the block is idle; csr_ready is high only when idle.
// Operand words enter on req_ when start is high and busy is low; each
// transaction stores one word pair. The transaction with req_operand_last
// set starts the computation and raises busy until all results are out.
// The product is built by a shift-add loop, one multiplier bit per cycle.
// The reducer then shifts the modulus up one bit per cycle until its top
// bit is set, and runs one conditional subtract per cycle, one more than
// there were shifts. Three results follow on consecutive cycles with
// rsp_valid high; the receiver cannot stall them. A zero modulus skips
// the arithmetic and gives three zero words with rsp_error set, the first
// in the cycle after the last word is accepted. Reset returns to idle.
// ----------------------------------------------------------------------------
module modular_multiply_restoring (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [mmr_pkg::WORD_W-1:0]   req_a_word,
   input  logic [mmr_pkg::WORD_W-1:0]   req_b_word,
   input  logic [mmr_pkg::IDX_W-1:0]    req_word_index,
   input  logic                         req_operand_last,
   output logic                         rsp_valid,
   output logic [mmr_pkg::WORD_W-1:0]   rsp_product_word,
   output logic [mmr_pkg::IDX_W-1:0]    rsp_out_index,
   output logic                         rsp_out_last,
   output logic                         rsp_error,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mmr_pkg::IDX_W-1:0]    csr_index,
   input  logic [mmr_pkg::WORD_W-1:0]   csr_data
);
   import mmr_pkg::*;

   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_WORDS - 1);
   localparam logic [MCNT_W-1:0] MUL_LAST = MCNT_W'(OP_W - 1);

   top_state_type       state_ff, state_in;
   logic [WORD_W-1:0]   a_store_ff [NUM_WORDS];
   logic [WORD_W-1:0]   b_store_ff [NUM_WORDS];
   logic [WORD_W-1:0]   mod_ff [NUM_WORDS];
   logic [OP_W-1:0]     mul_a_ff;
   logic [OP_W-1:0]     mul_lo_ff;
   logic [OP_W-1:0]     mul_hi_ff;
   logic [OP_W:0]       mul_sum;
   logic [MCNT_W-1:0]   mul_cnt_ff;
   logic [IDX_W-1:0]    out_cnt_ff;
   logic                err_ff;
   logic                accept, compute_go, mod_zero, red_start;
   logic [OP_W-1:0]     modulus, rem;
   red_status_type      red_status;

   assign accept     = start && !busy;
   assign compute_go = accept && req_operand_last;
   assign modulus    = {mod_ff[2], mod_ff[1], mod_ff[0]};
   assign mod_zero   = (modulus == '0);
   assign csr_ready  = (state_ff == ST_IDLE);

   // The current operand word is merged in so a last word takes part at once.
   logic [OP_W-1:0] a_full, b_full;
   always_comb begin
      for (int i = 0; i < NUM_WORDS; i++) begin
         a_full[i*WORD_W +: WORD_W] = a_store_ff[i];
         b_full[i*WORD_W +: WORD_W] = b_store_ff[i];
         if (req_word_index == IDX_W'(i)) begin
            a_full[i*WORD_W +: WORD_W] = req_a_word;
            b_full[i*WORD_W +: WORD_W] = req_b_word;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (compute_go) state_in = mod_zero ? ST_OUT : ST_MUL;
         ST_MUL:  if (mul_cnt_ff == MUL_LAST) state_in = ST_RED;
         ST_RED:  if (red_status.done) state_in = ST_OUT;
         ST_OUT:  if (out_cnt_ff == LAST_IDX) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy             = (state_ff != ST_IDLE);
      rsp_valid        = (state_ff == ST_OUT);
      rsp_out_index    = out_cnt_ff;
      rsp_out_last     = (out_cnt_ff == LAST_IDX);
      rsp_error        = err_ff;
      rsp_product_word = '0;
      if (!err_ff) begin
         unique case (out_cnt_ff)
            2'd0:    rsp_product_word = rem[0*WORD_W +: WORD_W];
            2'd1:    rsp_product_word = rem[1*WORD_W +: WORD_W];
            default: rsp_product_word = rem[2*WORD_W +: WORD_W];
         endcase
      end
      red_start = (state_ff == ST_MUL) && (mul_cnt_ff == MUL_LAST);
   end

   assign mul_sum = {1'b0, mul_hi_ff} + (mul_lo_ff[0] ? {1'b0, mul_a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mul_cnt_ff <= '0;
         out_cnt_ff <= '0;
         err_ff     <= 1'b0;
         for (int i = 0; i < NUM_WORDS; i++) mod_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready && state_ff == ST_IDLE) begin
            for (int i = 0; i < NUM_WORDS; i++)
               if (csr_index == IDX_W'(i)) mod_ff[i] <= csr_data;
         end
         if (compute_go) begin
            err_ff     <= mod_zero;
            mul_cnt_ff <= '0;
            out_cnt_ff <= '0;
         end
         if (state_ff == ST_MUL) mul_cnt_ff <= mul_cnt_ff + MCNT_W'(1);
         if (state_ff == ST_OUT) out_cnt_ff <= out_cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            if (req_word_index == IDX_W'(i)) begin
               a_store_ff[i] <= req_a_word;
               b_store_ff[i] <= req_b_word;
            end
         end
      end
      if (compute_go) begin
         mul_a_ff  <= a_full;
         mul_lo_ff <= b_full;
         mul_hi_ff <= '0;
      end else if (state_ff == ST_MUL) begin
         // Multiplier bits leave at the bottom; product low bits enter at the top.
         mul_hi_ff <= mul_sum[OP_W:1];
         mul_lo_ff <= {mul_sum[0], mul_lo_ff[OP_W-1:1]};
      end
   end

   mmr_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .product   ({mul_sum[OP_W:1], mul_sum[0], mul_lo_ff[OP_W-1:1]}),
      .modulus   (modulus),
      .remainder (rem),
      .status    (red_status)
   );

`ifndef SYNTHESIS
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |=> !busy)
      else $error("block still busy after the last result");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_product_word == '0)
      else $error("error result carries a nonzero word");
   a_go_mul: assert property (@(posedge clock) disable iff (reset)
      compute_go && !mod_zero |=> state_ff == ST_MUL)
      else $error("nonzero modulus did not start the multiply");
   a_red_done: assert property (@(posedge clock) disable iff (reset)
      red_status.done |-> state_ff == ST_RED)
      else $error("reducer finished outside the reduce phase");
`endif

endmodule
